// ===== rtl/led_strip_frame_gamma_encoder_macros.svh =====
// assertion macros shared by the checker
`ifndef LED_STRIP_FRAME_GAMMA_ENCODER_MACROS_SVH
`define LED_STRIP_FRAME_GAMMA_ENCODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LSFG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LSFG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lsfg_pkg.sv =====
package lsfg_pkg;

    localparam int PIX_W = 21;
    localparam int COMP_W = 7;

    localparam logic FUNC_PAINT = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    localparam logic [7:0] BYTE_MARK = 8'h80;
    localparam logic [5:0] STRIP_LEN_RESET = 6'd32;

    // exact integer bounds for round((i/255)^2.5 * 127)
    localparam longint unsigned POW5_255 = 64'd1078203909375;
    localparam longint unsigned SQ_254 = 64'd64516;

    typedef logic [COMP_W-1:0] t_gamma_rom [256];

    typedef struct packed {
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] blue;
    } t_pixel;

    function automatic t_gamma_rom f_gamma_table();
        t_gamma_rom tab;
        longint unsigned x;
        longint unsigned rhs;
        longint unsigned t;
        int v;
        logic found;
        for (int i = 0; i < 256; i++) begin
            x = longint'(i);
            rhs = SQ_254 * x * x * x * x * x;
            tab[i] = '0;
            found = 1'b0;
            for (v = 127; v > 0; v--) begin
                t = 2 * longint'(v) - 1;
                if (!found && (t * t * POW5_255 <= rhs)) begin
                    tab[i] = COMP_W'(v);
                    found = 1'b1;
                end
            end
        end
        return tab;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = f_gamma_table();

endpackage

// ===== rtl/lsfg_in_if.sv =====
interface lsfg_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [4:0] first_led;
    logic [5:0] led_count;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       skip_black;

    modport source (
        output valid, func, first_led, led_count, red_in, green_in, blue_in, skip_black,
        input  ready
    );
    modport sink (
        input  valid, func, first_led, led_count, red_in, green_in, blue_in, skip_black,
        output ready
    );
endinterface

// ===== rtl/lsfg_out_if.sv =====
interface lsfg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] green_byte;
    logic [7:0] red_byte;
    logic [7:0] blue_byte;
    logic       latch_last;

    modport source (
        output valid, green_byte, red_byte, blue_byte, latch_last,
        input  ready
    );
    modport sink (
        input  valid, green_byte, red_byte, blue_byte, latch_last,
        output ready
    );
endinterface

// ===== rtl/lsfg_gamma.sv =====
module lsfg_gamma (
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    output lsfg_pkg::t_pixel     o_pixel
);

    assign o_pixel.green = lsfg_pkg::GAMMA_ROM[i_green];
    assign o_pixel.red   = lsfg_pkg::GAMMA_ROM[i_red];
    assign o_pixel.blue  = lsfg_pkg::GAMMA_ROM[i_blue];

endmodule

// ===== rtl/lsfg_store.sv =====
module lsfg_store #(
    parameter int DEPTH = 32,
    parameter int IW = 5
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [IW-1:0]              i_waddr,
    input  lsfg_pkg::t_pixel           i_wdata,
    input  logic [IW-1:0]              i_raddr,
    output lsfg_pkg::t_pixel           o_rdata
);

    lsfg_pkg::t_pixel r_mem [DEPTH];
    lsfg_pkg::t_pixel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/led_strip_frame_gamma_encoder.sv =====
// update: one beat per cycle while the output is not stalled, strip length (capped at
//   LED_MAX) + 1 beats ending with the all-zero latch beat; the input is held off meanwhile
// paint: led_count writes through the single store write port after the accept;
//   an ignored paint is accepted and dropped without writes
// reset: strip length returns to 32, then a clearing pass writes zero to all LED_MAX
//   store entries while the input is held off; config writes are taken throughout
module led_strip_frame_gamma_encoder #(
    parameter int LED_MAX = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [5:0]        i_cfg_wr_data,
    lsfg_in_if.sink           i_in,
    lsfg_out_if.source        o_out
);

    localparam int IW = (LED_MAX > 1) ? $clog2(LED_MAX) : 1;
    localparam int CW = $clog2(LED_MAX + 1);
    localparam int LW = (CW > 7) ? CW : 7;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PAINT = 2'd2;
    localparam logic [1:0] ST_UPD   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_addr, n_addr;
    logic [LW-1:0]    r_end;
    lsfg_pkg::t_pixel r_word;
    logic [5:0]       r_strip;
    logic             r_out_v, n_out_v;
    logic [7:0]       r_out_g, r_out_r, r_out_b;
    logic             r_out_last;

    lsfg_pkg::t_pixel gamma_word;
    lsfg_pkg::t_pixel rdata;
    logic             we;
    logic [IW-1:0]    waddr;
    lsfg_pkg::t_pixel wdata;
    logic [IW-1:0]    raddr;

    logic [LW-1:0]    strip_ext;
    logic [LW-1:0]    eff_len;
    logic [LW-1:0]    paint_end;
    logic [LW-1:0]    addr_ext;
    logic [CW-1:0]    addr_inc;
    logic             in_acc;
    logic             is_black;
    logic             paint_ok;
    logic             out_free;
    logic             load;
    logic             load_latch;

    lsfg_gamma u_gamma (
        .i_red   (i_in.red_in),
        .i_green (i_in.green_in),
        .i_blue  (i_in.blue_in),
        .o_pixel (gamma_word)
    );

    lsfg_store #(
        .DEPTH (LED_MAX),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign strip_ext = LW'(r_strip);
    assign eff_len   = (strip_ext > LW'(LED_MAX)) ? LW'(LED_MAX) : strip_ext;
    assign paint_end = LW'(i_in.first_led) + LW'(i_in.led_count);
    assign addr_ext  = LW'(r_addr);
    assign addr_inc  = r_addr + 1'b1;
    assign in_acc    = i_in.valid && (r_state == ST_IDLE);
    assign is_black  = (i_in.red_in == 8'd0) && (i_in.green_in == 8'd0)
                       && (i_in.blue_in == 8'd0);
    assign paint_ok  = (paint_end <= eff_len) && (i_in.led_count != 6'd0)
                       && !(i_in.skip_black && is_black);
    assign out_free  = !r_out_v || o_out.ready;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        we         = 1'b0;
        waddr      = r_addr[IW-1:0];
        wdata      = r_word;
        raddr      = r_addr[IW-1:0];
        load       = 1'b0;
        load_latch = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                we     = 1'b1;
                wdata  = '0;
                n_addr = addr_inc;
                if (addr_ext == LW'(LED_MAX - 1)) begin
                    n_state = ST_IDLE;
                    n_addr  = '0;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.func == lsfg_pkg::FUNC_UPDATE) begin
                        n_state = ST_UPD;
                        n_addr  = '0;
                        raddr   = '0;
                    end else if (paint_ok) begin
                        n_state = ST_PAINT;
                        n_addr  = CW'(i_in.first_led);
                    end
                end
            end
            ST_PAINT: begin
                we     = 1'b1;
                n_addr = addr_inc;
                if (LW'(addr_inc) == r_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_UPD: begin
                // store data for r_addr is ready every cycle here, next address read ahead when a beat is loaded
                if (out_free) begin
                    load   = 1'b1;
                    n_addr = addr_inc;
                    raddr  = addr_inc[IW-1:0];
                    if (addr_ext == eff_len) begin
                        load_latch = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_v = r_out_v && !o_out.ready;
        if (load) begin
            n_out_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_out_v <= 1'b0;
            r_strip <= lsfg_pkg::STRIP_LEN_RESET;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_out_v <= n_out_v;
            if (i_cfg_wr_en) begin
                r_strip <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word <= gamma_word;
            r_end  <= paint_end;
        end
        if (load) begin
            if (load_latch) begin
                r_out_g    <= 8'd0;
                r_out_r    <= 8'd0;
                r_out_b    <= 8'd0;
                r_out_last <= 1'b1;
            end else begin
                r_out_g    <= lsfg_pkg::BYTE_MARK | 8'(rdata.green);
                r_out_r    <= lsfg_pkg::BYTE_MARK | 8'(rdata.red);
                r_out_b    <= lsfg_pkg::BYTE_MARK | 8'(rdata.blue);
                r_out_last <= 1'b0;
            end
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_v;
    assign o_out.green_byte = r_out_g;
    assign o_out.red_byte   = r_out_r;
    assign o_out.blue_byte  = r_out_b;
    assign o_out.latch_last = r_out_last;

endmodule

// ===== rtl/lsfg_checker.sv =====
`include "led_strip_frame_gamma_encoder_macros.svh"

module lsfg_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_in_func,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_green_byte,
    input  logic [7:0] i_red_byte,
    input  logic [7:0] i_blue_byte,
    input  logic       i_latch_last
);

    logic upd_acc;
    logic out_stall;
    logic mark_ok;
    logic zero_ok;

    assign upd_acc   = i_in_valid && i_in_ready && (i_in_func == lsfg_pkg::FUNC_UPDATE);
    assign out_stall = i_out_valid && !i_out_ready;
    assign mark_ok   = i_green_byte[7] && i_red_byte[7] && i_blue_byte[7];
    assign zero_ok   = (i_green_byte == 8'd0) && (i_red_byte == 8'd0)
                       && (i_blue_byte == 8'd0);

    `LSFG_ASSERT_NEXT(a_out_hold, out_stall, i_out_valid && $stable({i_green_byte, i_red_byte, i_blue_byte, i_latch_last}), "stalled output beat changed")
    `LSFG_ASSERT_NOW(a_latch_zero, i_out_valid && i_latch_last, zero_ok, "latch beat not all zero")
    `LSFG_ASSERT_NOW(a_led_mark, i_out_valid && !i_latch_last, mark_ok, "led beat without top bits")
    `LSFG_ASSERT_NEXT(a_upd_busy, upd_acc, !i_in_ready, "input ready right after update")

endmodule

bind led_strip_frame_gamma_encoder lsfg_checker u_lsfg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_func    (i_in.func),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_green_byte (o_out.green_byte),
    .i_red_byte   (o_out.red_byte),
    .i_blue_byte  (o_out.blue_byte),
    .i_latch_last (o_out.latch_last)
);
